>>> design/fcpu_pkg.sv
// Fly camera pose update: shared constants, types and CORDIC table.
// No dependencies.
`default_nettype none
package fcpu_pkg;
   localparam int TURN      = 23040;
   localparam int HALF      = 11520;
   localparam int QUARTER   = 5760;
   localparam int PITCH_LIM = 5696;
   localparam int ONE_Q14   = 16384;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic [0:0] {
      CSR_MOVE_SPEED = 1'b0,
      CSR_LOOK_SENS  = 1'b1
   } csr_index_type;

   function automatic logic [21:0] atan_entry(input logic [4:0] idx);
      logic [21:0] r;
      begin
         unique case (idx)
            5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;
            5'd2: r = 22'd919879;   5'd3: r = 22'd466945;
            5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
            5'd6: r = 22'd58666;    5'd7: r = 22'd29335;
            5'd8: r = 22'd14668;    5'd9: r = 22'd7334;
            5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
            5'd12: r = 22'd917;     5'd13: r = 22'd458;
            5'd14: r = 22'd229;     5'd15: r = 22'd115;
            5'd16: r = 22'd57;      5'd17: r = 22'd29;
            5'd18: r = 22'd14;      5'd19: r = 22'd7;
            5'd20: r = 22'd4;       5'd21: r = 22'd2;
            5'd22: r = 22'd1;       default: r = 22'd0;
         endcase
         return r;
      end
   endfunction
endpackage
`default_nettype wire

>>> design/fcpu_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, signed a by signed b.
// Depends on fcpu_pkg.
`default_nettype none
module fcpu_serial_mul
   import fcpu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [17:0] a,
   input  wire logic signed [17:0] b,
   output logic                    done,
   output logic signed [35:0]      prod
);
   logic signed [35:0] acc_ff, acc_in;
   logic signed [35:0] mcand_ff, mcand_in;
   logic [17:0]        mplr_ff, mplr_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;

   always_comb begin
      acc_in = acc_ff; mcand_in = mcand_ff; mplr_in = mplr_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         acc_in = '0; mcand_in = 36'(a); mplr_in = b;
         cnt_in = 5'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         // top bit of b carries negative weight
         if (mplr_ff[0]) begin
            if (cnt_ff == 5'd17) acc_in = acc_ff - mcand_ff;
            else acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         mplr_in = mplr_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd17) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; mcand_ff <= mcand_in; mplr_ff <= mplr_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done = busy_ff && (cnt_ff == 5'd17);
   assign prod = acc_in;
endmodule
`default_nettype wire

>>> design/fcpu_cordic.sv
// Rotation-mode CORDIC, one iteration per cycle, fold to +-90 degrees first.
// Depends on fcpu_pkg.
`default_nettype none
module fcpu_cordic
   import fcpu_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [15:0] angle,
   output logic                    done,
   output logic signed [15:0]      sin_q14,
   output logic signed [15:0]      cos_q14
);
   localparam int IW = $clog2(CORDIC_STEPS + 1);
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [25:0] z_ff, z_in;
   logic [IW-1:0]      it_ff, it_in;
   logic               busy_ff, busy_in, flip_ff, flip_in;
   logic               done_ff, done_in;
   logic signed [16:0] a0, a1;
   logic signed [33:0] xs, ys, xr, yr;
   logic signed [21:0] sv, cv;

   always_comb begin
      a0 = 17'(angle);
      if (a0 < 0) a0 = a0 + 17'(TURN);
      if (a0 >= 17'(HALF)) a0 = a0 - 17'(TURN);
      a1 = a0; flip_in = flip_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; it_in = it_ff; busy_in = busy_ff;
      xs = x_ff >>> it_ff; ys = y_ff >>> it_ff;
      if (start) begin
         flip_in = 1'b0;
         if (a0 > 17'(QUARTER)) begin
            a1 = 17'(HALF) - a0; flip_in = 1'b1;
         end else if (a0 < -17'(QUARTER)) begin
            a1 = -17'(HALF) - a0; flip_in = 1'b1;
         end
         x_in = CORDIC_GAIN; y_in = '0; z_in = 26'(a1) <<< 10;
         it_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys; y_in = y_ff + xs;
            z_in = z_ff - 26'(atan_entry(5'(it_ff)));
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs;
            z_in = z_ff + 26'(atan_entry(5'(it_ff)));
         end
         it_in = it_ff + 1'b1;
         if (it_ff == IW'(CORDIC_STEPS - 1)) busy_in = 1'b0;
      end
   end

   // done rises in the same cycle that the last iteration lands in x/y
   assign done_in = busy_ff && (it_ff == IW'(CORDIC_STEPS - 1));

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; it_ff <= it_in; flip_ff <= flip_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      yr = y_ff + 34'sd32768;
      xr = x_ff + 34'sd32768;
      sv = 22'(yr >>> 16);
      cv = 22'(xr >>> 16);
      if (sv > 22'(ONE_Q14)) sv = 22'(ONE_Q14);
      if (sv < -22'(ONE_Q14)) sv = -22'(ONE_Q14);
      if (cv > 22'(ONE_Q14)) cv = 22'(ONE_Q14);
      if (cv < -22'(ONE_Q14)) cv = -22'(ONE_Q14);
      if (flip_ff) cv = -cv;
   end

   assign done = done_ff;
   assign sin_q14 = 16'(sv);
   assign cos_q14 = 16'(cv);
endmodule
`default_nettype wire

>>> design/fly_camera_pose_update.sv
// Fly camera pose update: top level sequencer, state and output register.
// Depends on fcpu_pkg, fcpu_serial_mul and fcpu_cordic.
//
// Usage: one req beat per tick carries the cursor position and six keys.
// One rsp beat follows with angles, position and the unit vectors.
// Work runs one item at a time: two serial multiplies for the cursor
// deltas, two CORDIC runs, then seven serial multiplies for the products
// and moves (always run, the keys only gate the add). The first tick skips
// the delta multiplies; the shift-add multiplier (one bit a cycle) dominates.
// req_tready is high only when the sequencer is idle and the result
// register is empty, so a stalled rsp holds the beat and blocks new items.
// The csr channel is always ready; write only while idle.
// Reset (synchronous, high) clears the reference flag, angles, position
// and restores move_speed 51 and look_sensitivity 102. The first item
// after reset only stores the cursor; angle deltas are then zero.
`default_nettype none
module fly_camera_pose_update
   import fcpu_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [15:0] cursor_x, [31:16] cursor_y, [32] fwd, [33] back, [34] left,
   // [35] right, [36] up, [37] down, [39:38] zero
   input  wire logic [39:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [14:0] yaw, [28:15] pitch, [60:29] pos_x, [92:61] pos_y,
   // [124:93] pos_z, [140:125] fwd_x, [156:141] fwd_y, [172:157] fwd_z,
   // [188:173] side_x, [204:189] side_z, [207:205] zero
   output logic [207:0]      rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [0:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_DYAW  = 9'b000000010,
      ST_DPIT  = 9'b000000100,
      ST_ANG   = 9'b000001000,
      ST_CYAW  = 9'b000010000,
      ST_CPIT  = 9'b000100000,
      ST_MUL   = 9'b001000000,
      ST_MOVE  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] speed_ff, sens_ff;
   logic        have_ref_ff;
   logic signed [15:0] last_x_ff, last_y_ff, cx_ff, cy_ff;
   logic [5:0]  keys_ff;
   logic [14:0] yaw_ff;
   logic signed [13:0] pitch_ff;
   logic [31:0] pos_ff [3];
   logic signed [31:0] dyaw_ff, dpit_ff;
   logic signed [15:0] sy_ff, cyw_ff, sp_ff, cp_ff, fx_ff, fz_ff;
   logic [3:0]  step_ff;
   logic        mstart_ff, cstart_ff, mstart_in, cstart_in;
   logic        out_v_ff;
   logic [207:0] out_ff;

   logic               m_done, c_done;
   logic signed [35:0] m_prod;
   logic signed [17:0] m_a, m_b;
   logic signed [15:0] c_angle, c_sin, c_cos;

   fcpu_serial_mul u_mul (.clock, .reset, .start(mstart_ff), .a(m_a), .b(m_b),
      .done(m_done), .prod(m_prod));
   fcpu_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (.clock, .reset,
      .start(cstart_ff), .angle(c_angle), .done(c_done), .sin_q14(c_sin),
      .cos_q14(c_cos));

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;
   assign c_angle = (state_ff == ST_CYAW) ? 16'(yaw_ff) : 16'(pitch_ff);

   // registered start pulses for the multiplier and the CORDIC, in the cycle
   // after the state that asks for them
   always_comb begin
      mstart_in = ((state_ff == ST_IDLE) && req_tvalid && req_tready && have_ref_ff)
                  || ((state_ff == ST_DYAW) && m_done)
                  || ((state_ff == ST_CPIT) && c_done)
                  || ((state_ff == ST_MUL) && m_done)
                  || ((state_ff == ST_MOVE) && m_done && (step_ff != 4'd6));
      cstart_in = (state_ff == ST_ANG) || ((state_ff == ST_CYAW) && c_done);
   end

   logic signed [17:0] spd_s, spd_n;
   logic signed [35:0] rnd;
   logic signed [31:0] qm;
   assign spd_s = 18'(speed_ff);
   assign spd_n = -18'(speed_ff);
   assign rnd = m_prod + 36'sd8192;
   assign qm  = 32'(rnd >>> 14);

   // Multiply schedule in ST_MUL / ST_MOVE:
   // 0: sy*cp -> fx, 1: cyw*cp -> -fz, 2..4: fwd move, 5..6: strafe move
   always_comb begin
      m_a = '0; m_b = '0;
      unique case (state_ff)
         ST_DYAW: begin m_a = 18'(cx_ff) - 18'(last_x_ff); m_b = 18'(sens_ff); end
         ST_DPIT: begin m_a = 18'(cy_ff) - 18'(last_y_ff); m_b = 18'(sens_ff); end
         ST_MUL: begin
            m_b = 18'(cp_ff);
            m_a = (step_ff == 4'd0) ? 18'(sy_ff) : 18'(cyw_ff);
         end
         ST_MOVE: begin
            unique case (step_ff)
               4'd2: m_a = 18'(fx_ff);
               4'd3: m_a = 18'(sp_ff);
               4'd4: m_a = 18'(fz_ff);
               4'd5: m_a = 18'(cyw_ff);
               default: m_a = 18'(sy_ff);
            endcase
            if (step_ff <= 4'd4) m_b = keys_ff[0] ? spd_s : spd_n;
            else m_b = keys_ff[2] ? spd_n : spd_s;
         end
         default: ;
      endcase
   end

   logic signed [35:0] dr;
   logic signed [31:0] ds, dyc, yaw_w, pit_w;
   always_comb begin
      dr = m_prod + 36'sd8;
      ds = 32'(dr >>> 4);
      dyc = ds;
      if (dyc > 32'sd23040) dyc = 32'sd23040;
      if (dyc < -32'sd23040) dyc = -32'sd23040;
      yaw_w = 32'(yaw_ff) + dyaw_ff;
      if (yaw_w > 32'(TURN)) yaw_w = yaw_w - 32'(TURN);
      if (yaw_w < 0) yaw_w = yaw_w + 32'(TURN);
      // pitch delta may be huge; saturate sum by sign
      pit_w = 32'(pitch_ff) + dpit_ff;
      if (dpit_ff > 32'sd20000) pit_w = 32'(PITCH_LIM);
      if (dpit_ff < -32'sd20000) pit_w = -32'(PITCH_LIM);
      if (pit_w > 32'(PITCH_LIM)) pit_w = 32'(PITCH_LIM);
      if (pit_w < -32'(PITCH_LIM)) pit_w = -32'(PITCH_LIM);
   end

   logic move_en;
   always_comb begin
      if (step_ff <= 4'd4) move_en = keys_ff[0] | keys_ff[1];
      else move_en = keys_ff[2] | keys_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; speed_ff <= 16'd51; sens_ff <= 16'd102;
         have_ref_ff <= 1'b0; last_x_ff <= '0; last_y_ff <= '0;
         yaw_ff <= '0; pitch_ff <= '0; out_v_ff <= 1'b0; step_ff <= '0;
         mstart_ff <= 1'b0; cstart_ff <= 1'b0;
         for (int k = 0; k < 3; k++) pos_ff[k] <= '0;
      end else begin
         mstart_ff <= mstart_in;
         cstart_ff <= cstart_in;
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_MOVE_SPEED: speed_ff <= csr_wdata;
               CSR_LOOK_SENS:  sens_ff  <= csr_wdata;
            endcase
         end
         // result register: loaded at the end of an item, held until taken
         out_v_ff <= (state_ff == ST_DONE) || (out_v_ff && !rsp_tready);
         unique case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               cx_ff <= req_tdata[15:0]; cy_ff <= req_tdata[31:16];
               keys_ff <= req_tdata[37:32];
               dyaw_ff <= '0; dpit_ff <= '0;
               if (have_ref_ff) state_ff <= ST_DYAW;
               else state_ff <= ST_ANG;
            end
            ST_DYAW: if (m_done) begin
               dyaw_ff <= dyc; state_ff <= ST_DPIT;
            end
            ST_DPIT: if (m_done) begin
               dpit_ff <= ds; state_ff <= ST_ANG;
            end
            ST_ANG: begin
               have_ref_ff <= 1'b1; last_x_ff <= cx_ff; last_y_ff <= cy_ff;
               yaw_ff <= 15'(yaw_w); pitch_ff <= 14'(pit_w);
               state_ff <= ST_CYAW;
            end
            ST_CYAW: if (c_done) begin
               sy_ff <= c_sin; cyw_ff <= c_cos; state_ff <= ST_CPIT;
            end
            ST_CPIT: if (c_done) begin
               sp_ff <= c_sin; cp_ff <= c_cos; step_ff <= '0;
               state_ff <= ST_MUL;
            end
            ST_MUL: if (m_done) begin
               if (step_ff == 4'd0) begin
                  fx_ff <= 16'(qm); step_ff <= 4'd1;
               end else begin
                  fz_ff <= -16'(qm); step_ff <= 4'd2;
                  state_ff <= ST_MOVE;
               end
            end
            ST_MOVE: if (m_done) begin
               if (move_en) begin
                  unique case (step_ff)
                     4'd2, 4'd5: pos_ff[0] <= pos_ff[0] + 32'(qm);
                     4'd3:       pos_ff[1] <= pos_ff[1] + 32'(qm);
                     default:    pos_ff[2] <= pos_ff[2] + 32'(qm);
                  endcase
               end
               if (step_ff == 4'd6) state_ff <= ST_DONE;
               else step_ff <= step_ff + 4'd1;
            end
            ST_DONE: begin
               if (keys_ff[4]) pos_ff[1] <= pos_ff[1] + 32'(speed_ff);
               else if (keys_ff[5]) pos_ff[1] <= pos_ff[1] - 32'(speed_ff);
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   logic [31:0] py_fin;
   always_comb begin
      if (keys_ff[4]) py_fin = pos_ff[1] + 32'(speed_ff);
      else if (keys_ff[5]) py_fin = pos_ff[1] - 32'(speed_ff);
      else py_fin = pos_ff[1];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE)
         out_ff <= {3'b000, sy_ff, cyw_ff, fz_ff, sp_ff, fx_ff,
                    pos_ff[2], py_fin, pos_ff[0], pitch_ff, yaw_ff};
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_tvalid) else $error("result lost");
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      yaw_ff <= 15'(TURN)) else $error("yaw out of range");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      pitch_ff <= 14'(PITCH_LIM) && pitch_ff >= -14'(PITCH_LIM))
      else $error("pitch out of range");
endmodule
`default_nettype wire
